// ===== rtl/raid_pkg.sv =====
// Shared types and constants for the RAID-4 XOR parity engine.
package raid_pkg;

    localparam int BYTE_W   = 8;
    localparam int LANE_CAP = 7;
    localparam int LANE_W   = 3;
    localparam int BLK_W    = 13;
    localparam int CNT_W    = 12;
    localparam int IDX_W    = 11;

    localparam int DEF_MAX_HOSTS = 8;
    localparam int DEF_MAX_BLOCK = 4096;

    // Configuration register indexes
    localparam logic REG_STRIPES = 1'b0;
    localparam logic REG_BLOCK   = 1'b1;

    typedef enum logic [1:0] {
        MODE_GEN    = 2'd0,
        MODE_CHECK  = 2'd1,
        MODE_REPAIR = 2'd2
    } mode_t;

    // Block geometry derived from the configuration
    typedef struct packed {
        logic [CNT_W-1:0]  last_idx;
        logic [CNT_W-1:0]  full_cols;
        logic [LANE_W-1:0] rem;
    } geom_t;

    // Per-column result from the merge stage
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              mismatch;
    } col_res_t;

endpackage

// ===== rtl/raid4_xor_parity_engine.sv =====
// An accepted input item's result is on the output register in the cycle after it is accepted.
// Throughput: one item per cycle unless the output stalls or input is held off; each lane
// and the merge stage work in the accept cycle. After reset and after each configuration write,
// input is held off while the bit-serial divider derives column count and short-column width.
// Reset: rst_n clears the column counter, fault flag and output valid; config returns to 2/4096.
module raid4_xor_parity_engine
#(
    parameter int MAX_HOSTS_P     = raid_pkg::DEF_MAX_HOSTS,
    parameter int MAX_BLOCK_BYTES = raid_pkg::DEF_MAX_BLOCK
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [12:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // data_lanes[55:0], parity_in[63:56]
    input  logic [4:0]  s_tuser,   // mode[1:0], missing_stripe[4:2]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte[7:0], column_index[18:8], zero[23:19]
    output logic [2:0]  m_tuser,   // out_valid[0], column_mismatch[1], fault_seen[2]
    output logic        m_tlast    // last_column
);
    import raid_pkg::*;

    localparam int HOSTS_HI  = (MAX_HOSTS_P - 1 > LANE_CAP) ? LANE_CAP : MAX_HOSTS_P - 1;
    localparam int NUM_LANES = (HOSTS_HI < 2) ? 2 : HOSTS_HI;
    localparam int BLK_MAX   = (1 << BLK_W) - 1;
    localparam int BLK_HI    = (MAX_BLOCK_BYTES > BLK_MAX) ? BLK_MAX : MAX_BLOCK_BYTES;

    localparam logic [LANE_W-1:0] S_HI = LANE_W'(NUM_LANES);
    localparam logic [LANE_W-1:0] S_LO = LANE_W'(2);
    localparam logic [BLK_W-1:0]  B_HI = BLK_W'(BLK_HI);
    localparam logic [BLK_W-1:0]  B_LO = BLK_W'(2);

    logic [LANE_W-1:0] stripes_reg;
    logic [BLK_W-1:0]  block_reg;
    logic              start_reg;
    logic [LANE_W-1:0] s_eff;
    logic [BLK_W-1:0]  b_eff;
    logic              div_busy;
    geom_t             geom;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              fault_reg;
    logic              fault_next;
    logic              fault_seen;

    logic              last_col;
    logic              short_col;
    logic [LANE_W-1:0] nlanes;
    logic              accept;
    mode_t             mode;
    logic [LANE_W-1:0] miss;
    col_res_t          res;

    logic [NUM_LANES-1:0][BYTE_W-1:0] lane_x;
    logic [NUM_LANES-1:0][BYTE_W-1:0] lane_xr;

    logic              ovalid_reg;
    logic [BYTE_W-1:0] obyte_reg;
    logic              oflag_reg;
    logic              omism_reg;
    logic              ofault_reg;
    logic [IDX_W-1:0]  oidx_reg;
    logic              olast_reg;

    // Configuration registers; any write restarts the geometry divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stripes_reg <= LANE_W'(2);
            block_reg   <= BLK_W'(DEF_MAX_BLOCK);
            start_reg   <= 1'b1;
        end
        else
        begin
            start_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_STRIPES: stripes_reg <= cfg_wdata[LANE_W-1:0];
                    REG_BLOCK:   block_reg   <= cfg_wdata[BLK_W-1:0];
                    default:     stripes_reg <= stripes_reg;
                endcase
            end
        end
    end

    // Clamp configuration to the supported range
    always_comb
    begin
        s_eff = stripes_reg;
        if (s_eff < S_LO)
        begin
            s_eff = S_LO;
        end
        else if (s_eff > S_HI)
        begin
            s_eff = S_HI;
        end
        b_eff = block_reg;
        if (b_eff < B_LO)
        begin
            b_eff = B_LO;
        end
        else if (b_eff > B_HI)
        begin
            b_eff = B_HI;
        end
    end

    raid_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (b_eff),
        .divisor  (s_eff),
        .busy     (div_busy),
        .geom     (geom)
    );

    // Handshake: take an item when the output register frees up and the divider is neither starting nor busy
    assign s_tready = !start_reg && !div_busy && (!ovalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser[1:0]);
    assign miss     = s_tuser[4:2];

    // Column position within the block
    always_comb
    begin
        last_col  = (cnt_reg >= geom.last_idx);
        short_col = last_col && (geom.rem != '0) && (cnt_reg >= geom.full_cols);
        nlanes    = short_col ? geom.rem : s_eff;
    end

    // Lanes
    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_lane
        raid_lane #(.LANE_IDX(j)) u_lane
        (
            .lane_byte (s_tdata[BYTE_W*j +: BYTE_W]),
            .nlanes    (nlanes),
            .miss      (miss),
            .x_byte    (lane_x[j]),
            .xr_byte   (lane_xr[j])
        );
    end

    raid_merge #(.NUM_LANES(NUM_LANES)) u_merge
    (
        .lane_x  (lane_x),
        .lane_xr (lane_xr),
        .mode    (mode),
        .miss    (miss),
        .nlanes  (nlanes),
        .parity  (s_tdata[63:56]),
        .res     (res)
    );

    // Advance the counter; clear counter and fault after the last column
    always_comb
    begin
        fault_seen = fault_reg | res.mismatch;
        if (last_col)
        begin
            cnt_next   = '0;
            fault_next = 1'b0;
        end
        else
        begin
            cnt_next   = cnt_reg + 1'b1;
            fault_next = fault_seen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            fault_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg   <= cnt_next;
                fault_reg <= fault_next;
            end
            if (accept)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            obyte_reg  <= res.out_byte;
            oflag_reg  <= res.out_valid;
            omism_reg  <= res.mismatch;
            ofault_reg <= fault_seen;
            oidx_reg   <= cnt_reg[IDX_W-1:0];
            olast_reg  <= last_col;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'b0, oidx_reg, obyte_reg};
    assign m_tuser  = {ofault_reg, omism_reg, oflag_reg};
    assign m_tlast  = olast_reg;

endmodule

// ===== rtl/raid_div.sv =====
// Bit-serial divider that derives the block geometry from the configuration.
module raid_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [raid_pkg::BLK_W-1:0]    dividend,
    input  logic [raid_pkg::LANE_W-1:0]   divisor,
    output logic                          busy,
    output raid_pkg::geom_t               geom
);
    import raid_pkg::*;

    localparam int STEP_W = $clog2(BLK_W + 1);

    logic [BLK_W-1:0]  quo_reg;
    logic [BLK_W-1:0]  quo_next;
    logic [LANE_W-1:0] rem_reg;
    logic [LANE_W-1:0] rem_next;
    logic [LANE_W-1:0] dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic [LANE_W:0]   trial;
    logic [LANE_W:0]   diff;
    logic              ge;
    logic [CNT_W-1:0]  full_next;
    geom_t             geom_reg;

    // One quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[BLK_W-1]};
        ge        = (trial >= {1'b0, dsr_reg});
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = ge ? diff[LANE_W-1:0] : trial[LANE_W-1:0];
        quo_next  = {quo_reg[BLK_W-2:0], ge};
        full_next = quo_next[CNT_W-1:0];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            step_reg <= STEP_W'(BLK_W);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // Datapath and final geometry
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            if (step_reg == STEP_W'(1))
            begin
                geom_reg.full_cols <= full_next;
                geom_reg.rem       <= rem_next;
                geom_reg.last_idx  <= (rem_next != '0) ? full_next : full_next - 1'b1;
            end
        end
    end

    assign busy = run_reg;
    assign geom = geom_reg;

endmodule

// ===== rtl/raid_lane.sv =====
// One byte lane: gates its stripe byte for the parity and repair sums.
module raid_lane
#(
    parameter int LANE_IDX = 0
)
(
    input  logic [raid_pkg::BYTE_W-1:0] lane_byte,
    input  logic [raid_pkg::LANE_W-1:0] nlanes,
    input  logic [raid_pkg::LANE_W-1:0] miss,
    output logic [raid_pkg::BYTE_W-1:0] x_byte,
    output logic [raid_pkg::BYTE_W-1:0] xr_byte
);
    import raid_pkg::*;

    localparam logic [LANE_W-1:0] IDX = LANE_W'(LANE_IDX);

    logic active;
    logic keep;

    // Drop lanes outside this column, and the lost lane for repair
    always_comb
    begin
        active  = (IDX < nlanes);
        keep    = active && (IDX != miss);
        x_byte  = active ? lane_byte : '0;
        xr_byte = keep ? lane_byte : '0;
    end

endmodule

// ===== rtl/raid_merge.sv =====
// Merge stage: folds the lane bytes and applies the column mode.
module raid_merge
#(
    parameter int NUM_LANES = 7
)
(
    input  logic [NUM_LANES-1:0][raid_pkg::BYTE_W-1:0] lane_x,
    input  logic [NUM_LANES-1:0][raid_pkg::BYTE_W-1:0] lane_xr,
    input  raid_pkg::mode_t                              mode,
    input  logic [raid_pkg::LANE_W-1:0]                 miss,
    input  logic [raid_pkg::LANE_W-1:0]                 nlanes,
    input  logic [raid_pkg::BYTE_W-1:0]                 parity,
    output raid_pkg::col_res_t                           res
);
    import raid_pkg::*;

    logic [BYTE_W-1:0] x_sum;
    logic [BYTE_W-1:0] xr_sum;

    // Fold the lanes
    always_comb
    begin
        x_sum  = '0;
        xr_sum = '0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            x_sum  = x_sum ^ lane_x[j];
            xr_sum = xr_sum ^ lane_xr[j];
        end
    end

    // Apply mode; an unknown mode generates
    always_comb
    begin
        res.out_byte  = x_sum;
        res.out_valid = 1'b1;
        res.mismatch  = 1'b0;
        case (mode)
            MODE_REPAIR:
            begin
                if (miss < nlanes)
                begin
                    res.out_byte = xr_sum ^ parity;
                end
                else
                begin
                    res.out_byte  = '0;
                    res.out_valid = 1'b0;
                end
            end
            MODE_CHECK:
            begin
                res.mismatch = (x_sum != parity);
            end
            default:
            begin
                res.out_byte = x_sum;
            end
        endcase
    end

endmodule

// ===== rtl/raid_chk.sv =====
// Port checker for the RAID-4 XOR parity engine, bound to the top level.
module raid_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result item changed while stalled");

    // A mismatch must show in the sticky fault flag, with out_valid set
    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[2] && m_tuser[0])
        else $error("mismatch without fault flag");

    // An invalid repair carries a zero byte
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
        else $error("invalid result with nonzero byte");

    // An accepted input item shows on the output in the cycle after it is accepted
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // Pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:19] == 5'b0)
        else $error("pad bits set");

endmodule

bind raid4_xor_parity_engine raid_chk u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
